### hw/rtl/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg: shared types and constants for the PLL factor search
// Holds the sequencer state encoding, register and source codes, clock range
// limits and the fixed reciprocal used for the divide-by-three step.
// ----------------------------------------------------------------------------
`default_nettype none

package pfs_pkg;

    // Width of one configuration register (reference frequency in Hz).
    localparam int unsigned REG_W = 27;

    // Configuration register indexes.
    localparam logic [1:0] REG_MSI = 2'd0;
    localparam logic [1:0] REG_HSI = 2'd1;
    localparam logic [1:0] REG_HSE = 2'd2;

    // Reference source codes on the input item.
    localparam logic [1:0] SRC_MSI = 2'd0;
    localparam logic [1:0] SRC_HSI = 2'd1;
    localparam logic [1:0] SRC_HSE = 2'd2;

    // Register values after reset.
    localparam logic [REG_W-1:0] MSI_RESET_HZ = 27'd4000000;
    localparam logic [REG_W-1:0] HSI_RESET_HZ = 27'd16000000;
    localparam logic [REG_W-1:0] HSE_RESET_HZ = 27'd8000000;

    // PLL input window, output window and loop bounds.
    localparam logic [REG_W-1:0] VCO_IN_MIN  = 27'd1000000;
    localparam logic [REG_W-1:0] VCO_IN_MAX  = 27'd2000000;
    localparam logic [28:0]      VCO_OUT_MIN = 29'd64000000;
    localparam logic [28:0]      VCO_OUT_MAX = 29'd432000000;
    localparam logic [3:0]       M_MAX       = 4'd8;
    localparam logic [6:0]       N_MIN       = 7'd8;
    localparam logic [6:0]       N_MAX       = 7'd86;
    localparam logic [4:0]       DIV_LAST    = 5'd26;

    // Flash wait-state step in Hz.
    localparam logic [31:0] WAIT_STEP_HZ = 32'd30000000;

    // floor(x / 3) = (x * RECIP3) >> RECIP3_SHIFT, exact for x below 2^27.
    localparam logic [27:0]  RECIP3       = 28'd178956971;
    localparam int unsigned  RECIP3_SHIFT = 29;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_FLASH   = 7'b0000010,
        ST_DIV     = 7'b0000100,
        ST_M_CHECK = 7'b0001000,
        ST_N_CHECK = 7'b0010000,
        ST_P_TRY   = 7'b0100000,
        ST_DONE    = 7'b1000000
    } pfs_state_t;

endpackage : pfs_pkg

`default_nettype wire

### hw/rtl/pll_factor_search.sv
// ----------------------------------------------------------------------------
// pll_factor_search: PLL divider and multiplier search
// Finds the pre-divider, multiplier and post-divider that give the highest
// core clock not above a requested target, with derived bus clocks and
// flash wait states.
// ----------------------------------------------------------------------------
// One item is searched at a time; s_ready is high only while the block is
// idle. For an item the block first counts the flash wait states by repeated
// subtraction of 30 MHz, then for each pre-divider value (eight values) runs
// the bit-serial divide of the reference and its window check, and, for each
// pre-divider whose PLL input lands in the 1 to 2 MHz window (at most five),
// checks the range of each multiplier value and tries the four post-dividers
// for each multiplier whose VCO is in range. The result is held on the m_
// ports until it is taken, and the next item can be accepted in the cycle
// after that. Reference frequencies are to be written through the cfg_ port
// only while the block is idle; the block itself does not enforce this. An
// index of three is ignored.
`default_nettype none

module pll_factor_search (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Configuration write port
    input  wire logic                      cfg_wr_en,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [pfs_pkg::REG_W-1:0] cfg_wr_data,
    // Input items
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [31:0]               s_target_hz,
    input  wire logic [1:0]                s_source_select,
    // Result items
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [3:0]                     m_pre_divider,
    output logic [6:0]                     m_vco_multiplier,
    output logic [3:0]                     m_post_divider,
    output logic [27:0]                    m_core_hz,
    output logic [25:0]                    m_apb1_hz,
    output logic [26:0]                    m_apb2_hz,
    output logic                           m_exact_match,
    output logic [2:0]                     m_flash_wait_states
);
    import pfs_pkg::*;

    // Control and configuration registers
    pfs_state_t       state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic [REG_W-1:0] msi_reg, hsi_reg, hse_reg;

    // Datapath registers
    logic [31:0]      target_reg, target_next;
    logic [REG_W-1:0] ref_reg, ref_next;
    logic [31:0]      wait_rem_reg, wait_rem_next;
    logic [2:0]       wait_cnt_reg, wait_cnt_next;
    logic [REG_W-1:0] dq_reg, dq_next;
    logic [2:0]       rem_reg, rem_next;
    logic [4:0]       bit_cnt_reg, bit_cnt_next;
    logic [3:0]       m_reg, m_next;
    logic [6:0]       n_reg, n_next;
    logic [1:0]       p_idx_reg, p_idx_next;
    logic [20:0]      vin_reg, vin_next;
    logic [27:0]      vco_reg, vco_next;
    logic [26:0]      div6_reg, div6_next;
    logic [3:0]       best_m_reg, best_m_next;
    logic [6:0]       best_n_reg, best_n_next;
    logic [3:0]       best_p_reg, best_p_next;
    logic [27:0]      best_core_reg, best_core_next;

    // Combinational helpers
    logic [REG_W-1:0] sel_ref;
    logic [3:0]       div_trial;
    logic             div_take;
    logic [54:0]      div3_prod;
    logic [26:0]      core_cand;
    logic [28:0]      vco_ext;
    logic             go_next_n;
    logic             go_next_m;

    // Reference chosen by the incoming item; unused code gives 0 Hz.
    always_comb begin
        case (s_source_select)
            SRC_MSI: sel_ref = msi_reg;
            SRC_HSI: sel_ref = hsi_reg;
            SRC_HSE: sel_ref = hse_reg;
            default: sel_ref = '0;
        endcase
    end

    // One restoring step of the shared reference divider.
    assign div_trial = {rem_reg, dq_reg[REG_W-1]};
    assign div_take  = (div_trial >= m_reg);

    // VCO/6 as (VCO/2)/3 through the fixed reciprocal.
    assign div3_prod = 55'(vco_reg[27:1]) * 55'(RECIP3);
    assign vco_ext   = {1'b0, vco_reg};

    // Core frequency for the post-divider under test.
    always_comb begin
        case (p_idx_reg)
            2'd0:    core_cand = vco_reg[27:1];
            2'd1:    core_cand = {1'b0, vco_reg[27:2]};
            2'd2:    core_cand = div6_reg;
            default: core_cand = {2'b00, vco_reg[27:3]};
        endcase
    end

    // Sequencer: next-state and datapath updates.
    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg;
        target_next    = target_reg;
        ref_next       = ref_reg;
        wait_rem_next  = wait_rem_reg;
        wait_cnt_next  = wait_cnt_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        m_next         = m_reg;
        n_next         = n_reg;
        p_idx_next     = p_idx_reg;
        vin_next       = vin_reg;
        vco_next       = vco_reg;
        div6_next      = div6_reg;
        best_m_next    = best_m_reg;
        best_n_next    = best_n_reg;
        best_p_next    = best_p_reg;
        best_core_next = best_core_reg;
        go_next_n      = 1'b0;
        go_next_m      = 1'b0;
        s_ready        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    target_next    = s_target_hz;
                    ref_next       = sel_ref;
                    wait_rem_next  = s_target_hz;
                    wait_cnt_next  = '0;
                    best_m_next    = '0;
                    best_n_next    = '0;
                    best_p_next    = '0;
                    best_core_next = '0;
                    state_next     = ST_FLASH;
                end
            end
            ST_FLASH: begin
                // Count 30 MHz steps; only the low three bits are kept.
                if (wait_rem_reg >= WAIT_STEP_HZ) begin
                    wait_rem_next = wait_rem_reg - WAIT_STEP_HZ;
                    wait_cnt_next = wait_cnt_reg + 3'd1;
                end else begin
                    m_next       = 4'd1;
                    dq_next      = ref_reg;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                dq_next  = {dq_reg[REG_W-2:0], div_take};
                rem_next = div_take ? 3'(div_trial - m_reg) : div_trial[2:0];
                if (bit_cnt_reg == DIV_LAST) begin
                    state_next = ST_M_CHECK;
                end else begin
                    bit_cnt_next = bit_cnt_reg + 5'd1;
                end
            end
            ST_M_CHECK: begin
                // Keep this pre-divider only if the PLL input is in range.
                if (dq_reg >= VCO_IN_MIN && dq_reg <= VCO_IN_MAX) begin
                    vin_next   = dq_reg[20:0];
                    n_next     = N_MIN;
                    vco_next   = {4'b0000, dq_reg[20:0], 3'b000};
                    state_next = ST_N_CHECK;
                end else begin
                    go_next_m = 1'b1;
                end
            end
            ST_N_CHECK: begin
                if (vco_ext >= VCO_OUT_MIN && vco_ext <= VCO_OUT_MAX) begin
                    div6_next  = {1'b0, div3_prod[RECIP3_SHIFT+25:RECIP3_SHIFT]};
                    p_idx_next = '0;
                    state_next = ST_P_TRY;
                end else begin
                    go_next_n = 1'b1;
                end
            end
            ST_P_TRY: begin
                // Strictly higher wins, so the first setting keeps a tie.
                if ({5'b0, core_cand} <= target_reg &&
                    {1'b0, core_cand} > best_core_reg) begin
                    best_core_next = {1'b0, core_cand};
                    best_m_next    = m_reg;
                    best_n_next    = n_reg;
                    best_p_next    = {({1'b0, p_idx_reg} + 3'd1), 1'b0};
                end
                if (p_idx_reg == 2'd3) begin
                    go_next_n = 1'b1;
                end else begin
                    p_idx_next = p_idx_reg + 2'd1;
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b0;
            end
        endcase

        // Advance the multiplier; the VCO grows by one PLL input step.
        if (go_next_n) begin
            if (n_reg == N_MAX) begin
                go_next_m = 1'b1;
            end else begin
                n_next     = n_reg + 7'd1;
                vco_next   = vco_reg + {7'b0, vin_reg};
                state_next = ST_N_CHECK;
            end
        end

        // Advance the pre-divider and restart the reference divide.
        if (go_next_m) begin
            if (m_reg == M_MAX) begin
                m_valid_next = 1'b1;
                state_next   = ST_DONE;
            end else begin
                m_next       = m_reg + 4'd1;
                dq_next      = ref_reg;
                rem_next     = '0;
                bit_cnt_next = '0;
                state_next   = ST_DIV;
            end
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            msi_reg     <= MSI_RESET_HZ;
            hsi_reg     <= HSI_RESET_HZ;
            hse_reg     <= HSE_RESET_HZ;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MSI: msi_reg <= cfg_wr_data;
                    REG_HSI: hsi_reg <= cfg_wr_data;
                    REG_HSE: hse_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        target_reg    <= target_next;
        ref_reg       <= ref_next;
        wait_rem_reg  <= wait_rem_next;
        wait_cnt_reg  <= wait_cnt_next;
        dq_reg        <= dq_next;
        rem_reg       <= rem_next;
        bit_cnt_reg   <= bit_cnt_next;
        m_reg         <= m_next;
        n_reg         <= n_next;
        p_idx_reg     <= p_idx_next;
        vin_reg       <= vin_next;
        vco_reg       <= vco_next;
        div6_reg      <= div6_next;
        best_m_reg    <= best_m_next;
        best_n_reg    <= best_n_next;
        best_p_reg    <= best_p_next;
        best_core_reg <= best_core_next;
    end

    // Result item.
    assign m_valid             = m_valid_reg;
    assign m_pre_divider       = best_m_reg;
    assign m_vco_multiplier    = best_n_reg;
    assign m_post_divider      = best_p_reg;
    assign m_core_hz           = best_core_reg;
    assign m_apb1_hz           = best_core_reg[27:2];
    assign m_apb2_hz           = best_core_reg[27:1];
    assign m_exact_match       = (best_core_reg != '0) &&
                                 ({4'b0000, best_core_reg} == target_reg);
    assign m_flash_wait_states = wait_cnt_reg;

    // The block never takes an item while a result is pending.
    a_no_accept_with_result: assert property (
        @(posedge aclk) disable iff (!aresetn) m_valid |-> !s_ready
    ) else $error("input accepted while a result is pending");

    // An accepted item starts a search that blocks the input.
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn) (s_valid && s_ready) |=> !s_ready
    ) else $error("input ready right after an accept");

    // A nonzero result carries a complete PLL setting.
    a_setting_complete: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_core_hz != '0) |->
            (m_pre_divider != '0 && m_vco_multiplier >= N_MIN && m_post_divider != '0)
    ) else $error("nonzero core frequency without a full setting");

    // The chosen core frequency never exceeds the target.
    a_core_below_target: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({4'b0000, m_core_hz} <= target_reg)
    ) else $error("core frequency above target");

endmodule : pll_factor_search

`default_nettype wire
